>>> rtl/uf2_block_sequence_checker_assert.svh
// Assertion macros for the UF2 block sequence checker.
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef UF2_BLOCK_SEQUENCE_CHECKER_ASSERT_SVH
`define UF2_BLOCK_SEQUENCE_CHECKER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define UF2BSC_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("uf2bsc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define UF2BSC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("uf2bsc assertion failed");

`else

`define UF2BSC_ASSERT_SAME(label, ante, cons)
`define UF2BSC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> rtl/uf2bsc_pkg.sv
package uf2bsc_pkg;

   // Block geometry.
   localparam int PAGE_BYTES = 256;
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int INDEX_BITS = 16;
   localparam int ADDR_PAGE_BITS = 32 - PAGE_SHIFT;

   // Header constants.
   localparam logic [31:0] MAGIC_A     = 32'h0A32_4655;
   localparam logic [31:0] MAGIC_B     = 32'h9E5D_5157;
   localparam logic [31:0] MAGIC_Z     = 32'h0AB1_6F30;
   localparam logic [31:0] FLAG_FAMILY = 32'h0000_2000;

   // Configuration register indexes.
   localparam logic [2:0] REG_OTA_MODE     = 3'd0;
   localparam logic [2:0] REG_FAMILY_ID    = 3'd1;
   localparam logic [2:0] REG_FLASH_START  = 3'd2;
   localparam logic [2:0] REG_BOOT_RESERVE = 3'd3;
   localparam logic [2:0] REG_FLASH_SIZE   = 3'd4;

   // Configuration reset values.
   localparam logic [31:0] FAMILY_ID_RESET    = 32'hE48B_FF56;
   localparam logic [31:0] FLASH_START_RESET  = 32'h1000_0000;
   localparam logic [24:0] BOOT_RESERVE_RESET = 25'h000_4000;
   localparam logic [24:0] FLASH_SIZE_RESET   = 25'h100_0000;

   // Status codes.
   localparam logic [3:0] ST_OK       = 4'd0;
   localparam logic [3:0] ST_MAGIC_A  = 4'd1;
   localparam logic [3:0] ST_MAGIC_B  = 4'd2;
   localparam logic [3:0] ST_MAGIC_Z  = 4'd3;
   localparam logic [3:0] ST_FLAGS    = 4'd4;
   localparam logic [3:0] ST_FAMILY   = 4'd5;
   localparam logic [3:0] ST_SIZE     = 4'd6;
   localparam logic [3:0] ST_ALIGN    = 4'd7;
   localparam logic [3:0] ST_RANGE    = 4'd8;
   localparam logic [3:0] ST_NUMBER   = 4'd9;
   localparam logic [3:0] ST_COUNT    = 4'd10;
   localparam logic [3:0] ST_ORDER    = 4'd11;
   localparam logic [3:0] ST_GAP      = 4'd12;
   localparam logic [3:0] ST_SHORT    = 4'd13;

   typedef struct packed {
      logic [31:0] magic_first;
      logic [31:0] magic_second;
      logic [31:0] magic_final;
      logic [31:0] flags_word;
      logic [31:0] family_word;
      logic [31:0] payload_bytes;
      logic [31:0] target_address;
      logic [31:0] block_number;
      logic [31:0] block_count;
      logic        last_in_file;
   } header_type;

   typedef struct packed {
      logic        ota_mode;
      logic [31:0] family_id;
      logic [31:0] flash_start;
      logic [24:0] boot_reserve;
      logic [24:0] flash_size;
   } cfg_type;

   typedef struct packed {
      logic        awaiting_first;
      logic [31:0] next_block_number;
      logic [31:0] expected_count;
      logic [31:0] next_address;
      logic [31:0] first_address;
   } seq_state_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [31:0] base_address;
      logic [15:0] page_index;
      logic        file_complete;
   } result_type;

endpackage

>>> rtl/uf2bsc_check.sv
module uf2bsc_check
   import uf2bsc_pkg::*;
(
   input  header_type    hdr,
   input  cfg_type       cfg,
   input  seq_state_type state,
   output result_type    result,
   output seq_state_type state_next
);

   logic [3:0]  hdr_status;
   logic [32:0] window_lo;
   logic [32:0] window_hi;
   logic [32:0] target_end;
   logic [31:0] expected_number;
   logic [31:0] first_addr_new;
   logic [31:0] count_new;
   logic [31:0] number_inc;
   logic [31:0] page_offset;
   logic [ADDR_PAGE_BITS-1:0] page_full;
   logic [ADDR_PAGE_BITS-1:0] index_mask;

   // Flash window bounds, kept one bit wider so they never wrap.
   assign window_lo  = {1'b0, cfg.flash_start}
                     + (cfg.ota_mode ? {8'd0, cfg.boot_reserve} : 33'd0);
   assign window_hi  = {1'b0, cfg.flash_start} + {8'd0, cfg.flash_size};
   assign target_end = {1'b0, hdr.target_address} + 33'(PAGE_BYTES);

   assign expected_number = state.awaiting_first ? 32'd0 : state.next_block_number;
   assign number_inc      = hdr.block_number + 32'd1;
   assign index_mask      = ADDR_PAGE_BITS'((64'd1 << INDEX_BITS) - 64'd1);

   // Header checks in file order; the first failure wins.
   always_comb begin
      priority if (hdr.magic_first != MAGIC_A) begin
         hdr_status = ST_MAGIC_A;
      end else if (hdr.magic_second != MAGIC_B) begin
         hdr_status = ST_MAGIC_B;
      end else if (hdr.magic_final != MAGIC_Z) begin
         hdr_status = ST_MAGIC_Z;
      end else if (hdr.flags_word != FLAG_FAMILY) begin
         hdr_status = ST_FLAGS;
      end else if (hdr.family_word != cfg.family_id) begin
         hdr_status = ST_FAMILY;
      end else if (hdr.payload_bytes != 32'(PAGE_BYTES)) begin
         hdr_status = ST_SIZE;
      end else if (hdr.target_address[PAGE_SHIFT-1:0] != '0) begin
         hdr_status = ST_ALIGN;
      end else if (({1'b0, hdr.target_address} < window_lo) || (target_end > window_hi)) begin
         hdr_status = ST_RANGE;
      end else if (hdr.block_number >= hdr.block_count) begin
         hdr_status = ST_NUMBER;
      end else if (!state.awaiting_first && (hdr.block_count != state.expected_count)) begin
         hdr_status = ST_COUNT;
      end else begin
         hdr_status = ST_OK;
      end
   end

   // A first block sets the file's base and count.
   assign first_addr_new = state.awaiting_first ? hdr.target_address : state.first_address;
   assign count_new      = state.awaiting_first ? hdr.block_count : state.expected_count;
   assign page_offset    = hdr.target_address - first_addr_new;
   assign page_full      = page_offset[31:PAGE_SHIFT] & index_mask;

   // Sequence checks and the state update.
   always_comb begin
      result.status        = hdr_status;
      result.base_address  = state.first_address;
      result.page_index    = '0;
      result.file_complete = 1'b0;
      state_next           = state;

      if ((result.status == ST_OK) && (hdr.block_number != expected_number)) begin
         result.status = ST_ORDER;
      end
      if ((result.status == ST_OK) && !state.awaiting_first
          && (hdr.target_address != state.next_address)) begin
         result.status = ST_GAP;
      end

      if (result.status == ST_OK) begin
         state_next.awaiting_first    = 1'b0;
         state_next.first_address     = first_addr_new;
         state_next.expected_count    = count_new;
         state_next.next_block_number = number_inc;
         state_next.next_address      = hdr.target_address + 32'(PAGE_BYTES);
         result.base_address          = first_addr_new;
         result.page_index            = 16'(page_full);
         if (hdr.last_in_file) begin
            if (number_inc != count_new) begin
               result.status     = ST_SHORT;
               result.page_index = '0;
            end else begin
               result.file_complete = 1'b1;
            end
         end
      end

      // Errors and file ends both go back to waiting for a first block.
      if ((result.status != ST_OK) || hdr.last_in_file) begin
         state_next.awaiting_first    = 1'b1;
         state_next.next_block_number = '0;
      end
   end

endmodule

>>> rtl/uf2_block_sequence_checker.sv
// UF2 block sequence checker: one block header is taken per request and one
// status result is returned for each, at a sustained rate of one request per
// clock while rsp_stall is low. A request is registered in the input register on
// acceptance, checked from there by a single pass of compares and adds against
// the sequence state, and its result is registered in the result register;
// rsp_stall holds the result register and backs up into req_stall.
// Configuration writes are registered and should be made while idle.
`include "uf2_block_sequence_checker_assert.svh"

module uf2_block_sequence_checker
   import uf2bsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_magic_first,
   input  logic [31:0] req_magic_second,
   input  logic [31:0] req_magic_final,
   input  logic [31:0] req_flags_word,
   input  logic [31:0] req_family_word,
   input  logic [31:0] req_payload_bytes,
   input  logic [31:0] req_target_address,
   input  logic [31:0] req_block_number,
   input  logic [31:0] req_block_count,
   input  logic        req_last_in_file,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_status,
   output logic [31:0] rsp_base_address,
   output logic [15:0] rsp_page_index,
   output logic        rsp_file_complete
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   header_type    hdr_ff;
   header_type    hdr_in;
   logic          hdr_valid_ff;
   logic          hdr_valid_in;
   seq_state_type state_ff;
   seq_state_type state_in;
   result_type    rsp_ff;
   result_type    result;
   seq_state_type state_next;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic          req_take;
   logic          advance;

   // Configuration register writes; indexes past the list are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_OTA_MODE:     cfg_in.ota_mode     = csr_data[0];
            REG_FAMILY_ID:    cfg_in.family_id    = csr_data;
            REG_FLASH_START:  cfg_in.flash_start  = csr_data;
            REG_BOOT_RESERVE: cfg_in.boot_reserve = csr_data[24:0];
            REG_FLASH_SIZE:   cfg_in.flash_size   = csr_data[24:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ota_mode     <= 1'b0;
         cfg_ff.family_id    <= FAMILY_ID_RESET;
         cfg_ff.flash_start  <= FLASH_START_RESET;
         cfg_ff.boot_reserve <= BOOT_RESERVE_RESET;
         cfg_ff.flash_size   <= FLASH_SIZE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Pipeline handshake: the checked request moves on when the result slot frees.
   assign advance      = hdr_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = hdr_valid_ff && !advance;
   assign req_take     = req_valid && !req_stall;
   assign hdr_valid_in = req_take || (hdr_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   // Input register.
   always_comb begin
      hdr_in = hdr_ff;
      if (req_take) begin
         hdr_in.magic_first    = req_magic_first;
         hdr_in.magic_second   = req_magic_second;
         hdr_in.magic_final    = req_magic_final;
         hdr_in.flags_word     = req_flags_word;
         hdr_in.family_word    = req_family_word;
         hdr_in.payload_bytes  = req_payload_bytes;
         hdr_in.target_address = req_target_address;
         hdr_in.block_number   = req_block_number;
         hdr_in.block_count    = req_block_count;
         hdr_in.last_in_file   = req_last_in_file;
      end
   end

   always_ff @(posedge clock) begin
      hdr_ff <= hdr_in;
   end

   // Header and sequence checks.
   uf2bsc_check u_check (
      .hdr        (hdr_ff),
      .cfg        (cfg_ff),
      .state      (state_ff),
      .result     (result),
      .state_next (state_next)
   );

   // Sequence state advances with each checked request.
   assign state_in = advance ? state_next : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.awaiting_first    <= 1'b1;
         state_ff.next_block_number <= '0;
         state_ff.expected_count    <= '0;
         state_ff.next_address      <= '0;
         state_ff.first_address     <= '0;
         hdr_valid_ff               <= 1'b0;
         rsp_valid_ff               <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hdr_valid_ff <= hdr_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_ff.status;
   assign rsp_base_address  = rsp_ff.base_address;
   assign rsp_page_index    = rsp_ff.page_index;
   assign rsp_file_complete = rsp_ff.file_complete;

   // A completed file always carries a clean status.
   `UF2BSC_ASSERT_SAME(a_complete_ok, rsp_valid && rsp_file_complete, rsp_status == ST_OK)
   // A failed block reports no page index.
   `UF2BSC_ASSERT_SAME(a_err_no_index, rsp_valid && (rsp_status != ST_OK), rsp_page_index == 16'd0)
   // A held request stays in the input register.
   `UF2BSC_ASSERT_NEXT(a_hold_request, hdr_valid_ff && !advance, hdr_valid_ff)
   // A failing block sends the checker back to waiting for a first block.
   `UF2BSC_ASSERT_NEXT(a_err_restart, advance && (result.status != ST_OK),
                       state_ff.awaiting_first && (state_ff.next_block_number == 32'd0))

endmodule

>>> tb/sv/uf2_block_sequence_checker_test.sv
module uf2_block_sequence_checker_test;
   import uf2bsc_pkg::*;

   localparam int CLOCK_PERIOD = 10;
   localparam int TIMEOUT_CYCLES = 400000;
   localparam int REPORT_LINES = 40;

   // Writes to an index past the register list must be ignored.
   localparam logic [2:0] REG_SPARE = 3'd7;

   // Ways of breaking an otherwise good block header.
   typedef enum int {
      BREAK_MAGIC_A,
      BREAK_MAGIC_B,
      BREAK_MAGIC_Z,
      BREAK_FLAGS,
      BREAK_FAMILY,
      BREAK_SIZE,
      BREAK_ALIGN,
      BREAK_RANGE,
      BREAK_NUMBER,
      BREAK_COUNT,
      BREAK_ORDER,
      BREAK_GAP,
      BREAK_SEQUENCE,
      BREAK_KINDS
   } fault_kind_e;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_magic_first = '0;
   logic [31:0] req_magic_second = '0;
   logic [31:0] req_magic_final = '0;
   logic [31:0] req_flags_word = '0;
   logic [31:0] req_family_word = '0;
   logic [31:0] req_payload_bytes = '0;
   logic [31:0] req_target_address = '0;
   logic [31:0] req_block_number = '0;
   logic [31:0] req_block_count = '0;
   logic        req_last_in_file = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_status;
   logic [31:0] rsp_base_address;
   logic [15:0] rsp_page_index;
   logic        rsp_file_complete;

   // Local copy of the block's registers and sequence state.
   cfg_type       cfg_now;
   seq_state_type seq_now;

   header_type header_backlog[$];
   result_type pending_verdicts[$];
   header_type driven;

   int          sender_idle_pct = 0;
   int          receiver_idle_pct = 0;
   int          send_gap = 0;
   int          stall_left = 0;
   int          phase_items = 0;
   int          headers_sent = 0;
   int          verdicts_checked = 0;
   int          mismatch_count = 0;
   int          files_closed = 0;
   int          settings_used = 1;
   logic [15:0] status_seen = '0;

   uf2_block_sequence_checker DUT (
      .clock(clock),
      .reset(reset),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_magic_first(req_magic_first),
      .req_magic_second(req_magic_second),
      .req_magic_final(req_magic_final),
      .req_flags_word(req_flags_word),
      .req_family_word(req_family_word),
      .req_payload_bytes(req_payload_bytes),
      .req_target_address(req_target_address),
      .req_block_number(req_block_number),
      .req_block_count(req_block_count),
      .req_last_in_file(req_last_in_file),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_base_address(rsp_base_address),
      .rsp_page_index(rsp_page_index),
      .rsp_file_complete(rsp_file_complete)
   );

   always begin
      #(CLOCK_PERIOD / 2) clock = 1'b1;
      #(CLOCK_PERIOD / 2) clock = 1'b0;
   end

   initial begin
      cfg_now.ota_mode = 1'b0;
      cfg_now.family_id = FAMILY_ID_RESET;
      cfg_now.flash_start = FLASH_START_RESET;
      cfg_now.boot_reserve = BOOT_RESERVE_RESET;
      cfg_now.flash_size = FLASH_SIZE_RESET;
      seq_now = '0;
      seq_now.awaiting_first = 1'b1;
   end

   // Works out the verdict for one accepted header and advances the sequence state.
   function automatic result_type judge_header(input header_type h);
      longint     win_lo;
      longint     win_hi;
      longint     tgt;
      logic [31:0] want_number;
      logic [31:0] pages_in;
      result_type r;
      win_lo = longint'(cfg_now.flash_start)
               + (cfg_now.ota_mode ? longint'(cfg_now.boot_reserve) : 64'd0);
      win_hi = longint'(cfg_now.flash_start) + longint'(cfg_now.flash_size);
      tgt = longint'(h.target_address);
      want_number = seq_now.awaiting_first ? 32'd0 : seq_now.next_block_number;
      r = '0;
      r.status = ST_OK;
      if (h.magic_first != MAGIC_A) r.status = ST_MAGIC_A;
      else if (h.magic_second != MAGIC_B) r.status = ST_MAGIC_B;
      else if (h.magic_final != MAGIC_Z) r.status = ST_MAGIC_Z;
      else if (h.flags_word != FLAG_FAMILY) r.status = ST_FLAGS;
      else if (h.family_word != cfg_now.family_id) r.status = ST_FAMILY;
      else if (h.payload_bytes != 32'(PAGE_BYTES)) r.status = ST_SIZE;
      else if (h.target_address % PAGE_BYTES != 0) r.status = ST_ALIGN;
      else if (tgt < win_lo || tgt + PAGE_BYTES > win_hi) r.status = ST_RANGE;
      else if (h.block_number >= h.block_count) r.status = ST_NUMBER;
      else if (!seq_now.awaiting_first && h.block_count != seq_now.expected_count)
         r.status = ST_COUNT;
      else if (h.block_number != want_number) r.status = ST_ORDER;
      else if (!seq_now.awaiting_first && h.target_address != seq_now.next_address)
         r.status = ST_GAP;

      // A good header moves the sequence on; a last block then closes the file.
      if (r.status == ST_OK) begin
         if (seq_now.awaiting_first) begin
            seq_now.first_address = h.target_address;
            seq_now.expected_count = h.block_count;
            seq_now.awaiting_first = 1'b0;
         end
         seq_now.next_block_number = h.block_number + 32'd1;
         seq_now.next_address = h.target_address + 32'(PAGE_BYTES);
         pages_in = (h.target_address - seq_now.first_address) / PAGE_BYTES;
         r.page_index = 16'(pages_in & ((32'd1 << INDEX_BITS) - 32'd1));
         if (h.last_in_file) begin
            if (seq_now.next_block_number != seq_now.expected_count) begin
               r.status = ST_SHORT;
               r.page_index = '0;
            end else begin
               r.file_complete = 1'b1;
            end
         end
      end
      if (r.status != ST_OK || h.last_in_file) begin
         seq_now.awaiting_first = 1'b1;
         seq_now.next_block_number = '0;
      end
      r.base_address = seq_now.first_address;
      return r;
   endfunction

   // Mostly short pauses, now and then a long one.
   function automatic int pick_gap();
      if ($urandom_range(0, 99) < 85) return int'($urandom_range(1, 3));
      return int'($urandom_range(8, 40));
   endfunction

   function automatic logic [31:0] nonzero_mask();
      logic [31:0] v;
      v = $urandom;
      if (v == '0) v = 32'h1;
      return v;
   endfunction

   function automatic header_type good_block(input logic [31:0] number,
                                             input logic [31:0] count,
                                             input logic [31:0] address,
                                             input logic last);
      header_type h;
      h.magic_first = MAGIC_A;
      h.magic_second = MAGIC_B;
      h.magic_final = MAGIC_Z;
      h.flags_word = FLAG_FAMILY;
      h.family_word = cfg_now.family_id;
      h.payload_bytes = 32'(PAGE_BYTES);
      h.target_address = address;
      h.block_number = number;
      h.block_count = count;
      h.last_in_file = last;
      return h;
   endfunction

   // Either pure noise or a good preamble with random placement and numbering.
   function automatic header_type noise_header();
      header_type h;
      h = good_block($urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 1) == 1) begin
         h.magic_first = $urandom;
         h.magic_second = $urandom;
         h.magic_final = $urandom;
         h.flags_word = $urandom;
         h.family_word = $urandom;
         h.payload_bytes = $urandom;
      end
      return h;
   endfunction

   function automatic header_type damage(input header_type h);
      fault_kind_e kind;
      kind = fault_kind_e'($urandom_range(0, BREAK_KINDS - 1));
      case (kind)
         BREAK_MAGIC_A: h.magic_first ^= nonzero_mask();
         BREAK_MAGIC_B: h.magic_second ^= nonzero_mask();
         BREAK_MAGIC_Z: h.magic_final ^= nonzero_mask();
         BREAK_FLAGS: h.flags_word ^= nonzero_mask();
         BREAK_FAMILY: h.family_word ^= nonzero_mask();
         BREAK_SIZE: h.payload_bytes ^= nonzero_mask();
         BREAK_ALIGN: h.target_address ^= 32'($urandom_range(1, PAGE_BYTES - 1));
         BREAK_RANGE: h.target_address = $urandom & ~32'(PAGE_BYTES - 1);
         BREAK_NUMBER: h.block_number = h.block_count + 32'($urandom_range(0, 3));
         BREAK_COUNT: h.block_count ^= nonzero_mask();
         BREAK_ORDER: h.block_number += 32'($urandom_range(1, 3));
         BREAK_GAP: h.target_address += 32'($urandom_range(1, 4) * PAGE_BYTES);
         BREAK_SEQUENCE: begin
            h.block_number = $urandom;
            h.block_count = $urandom;
         end
         default: ;
      endcase
      return h;
   endfunction

   // Start address for a file, usually placed so the whole file fits the window.
   function automatic logic [31:0] pick_start(input int blocks);
      longint lo;
      longint hi;
      int     pages;
      int     page;
      lo = longint'(cfg_now.flash_start)
           + (cfg_now.ota_mode ? longint'(cfg_now.boot_reserve) : 64'd0);
      lo = (lo + PAGE_BYTES - 1) / PAGE_BYTES * PAGE_BYTES;
      hi = longint'(cfg_now.flash_start) + longint'(cfg_now.flash_size);
      if (hi > 64'h1_0000_0000) hi = 64'h1_0000_0000;
      if (hi < lo + PAGE_BYTES) return lo[31:0];
      pages = int'((hi - lo) / PAGE_BYTES);
      if ($urandom_range(0, 9) == 0) begin
         // Near the top, so later blocks may run out of the window.
         page = pages - 1 - int'($urandom_range(0, blocks - 1));
         if (page < 0) page = 0;
      end else begin
         page = int'($urandom_range(0, (pages > blocks) ? pages - blocks : 0));
      end
      return 32'(lo + longint'(page) * PAGE_BYTES);
   endfunction

   task automatic push_header(input header_type h);
      header_backlog.insert(header_backlog.size(), h);
      phase_items++;
   endtask

   // One file of blocks, sometimes broken, cut short or left open, or a stray header.
   task automatic queue_random_file();
      int          blocks;
      int          emitted;
      int          broken_at;
      bit          drop_last;
      logic [31:0] start;
      header_type  h;
      if ($urandom_range(0, 99) < 8) begin
         push_header(noise_header());
         return;
      end
      blocks = ($urandom_range(0, 99) < 80) ? int'($urandom_range(1, 6))
                                             : int'($urandom_range(7, 24));
      emitted = ($urandom_range(0, 9) == 0) ? int'($urandom_range(1, blocks)) : blocks;
      broken_at = ($urandom_range(0, 99) < 35) ? int'($urandom_range(0, emitted - 1)) : -1;
      drop_last = ($urandom_range(0, 19) == 0);
      start = pick_start(blocks);
      for (int i = 0; i < emitted; i++) begin
         h = good_block(i, blocks, start + 32'(i * PAGE_BYTES),
                        (i == emitted - 1) && !drop_last);
         if (i == broken_at) begin
            h = damage(h);
            push_header(h);
            if ($urandom_range(0, 1) == 1) break;
         end else begin
            push_header(h);
         end
      end
   endtask

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LINES) $display("MISMATCH: %s", what);
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      case (index)
         REG_OTA_MODE: cfg_now.ota_mode = value[0];
         REG_FAMILY_ID: cfg_now.family_id = value;
         REG_FLASH_START: cfg_now.flash_start = value;
         REG_BOOT_RESERVE: cfg_now.boot_reserve = value[24:0];
         REG_FLASH_SIZE: cfg_now.flash_size = value[24:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic ota, input logic [31:0] family,
                             input logic [31:0] base, input logic [24:0] boot,
                             input logic [24:0] size);
      write_reg(REG_OTA_MODE, {31'd0, ota});
      write_reg(REG_FAMILY_ID, family);
      write_reg(REG_FLASH_START, base);
      write_reg(REG_BOOT_RESERVE, {7'd0, boot});
      write_reg(REG_FLASH_SIZE, {7'd0, size});
      settings_used++;
   endtask

   // The sender holds off until every request has been answered.
   task automatic wait_drained();
      do @(negedge clock);
      while (header_backlog.size() != 0 || req_valid || pending_verdicts.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic run_random_phase(input int budget, input int send_pct, input int recv_pct);
      @(negedge clock);
      sender_idle_pct = send_pct;
      receiver_idle_pct = recv_pct;
      phase_items = 0;
      while (phase_items < budget) queue_random_file();
      wait_drained();
   endtask

   // Field extremes, each error code in turn, and the file-level cases.
   task automatic queue_directed();
      header_type  h;
      logic [31:0] base;
      logic [31:0] top;
      base = cfg_now.flash_start;
      top = cfg_now.flash_start + 32'(cfg_now.flash_size);
      push_header('0);
      push_header('1);
      h = good_block(0, 3, base, 1'b0);
      h.magic_second ^= 32'h1;
      push_header(h);
      h = good_block(0, 3, base, 1'b0);
      h.magic_final ^= 32'h8000_0000;
      push_header(h);
      h = good_block(0, 3, base, 1'b0);
      h.flags_word = FLAG_FAMILY | 32'h1;
      push_header(h);
      h = good_block(0, 3, base, 1'b0);
      h.family_word ^= 32'h8000_0000;
      push_header(h);
      h = good_block(0, 3, base, 1'b0);
      h.payload_bytes = 32'(2 * PAGE_BYTES);
      push_header(h);
      push_header(good_block(0, 3, base + 32'h80, 1'b0));
      push_header(good_block(0, 3, base - 32'(PAGE_BYTES), 1'b0));
      push_header(good_block(0, 3, top, 1'b0));
      push_header(good_block(3, 3, base, 1'b0));
      push_header(good_block(0, 0, base, 1'b0));
      // A first block that does not start at zero.
      push_header(good_block(2, 4, base, 1'b0));
      // Second block with a different count.
      push_header(good_block(0, 3, base, 1'b0));
      push_header(good_block(1, 4, base + 32'(PAGE_BYTES), 1'b0));
      // Skipped block number.
      push_header(good_block(0, 3, base, 1'b0));
      push_header(good_block(2, 3, base + 32'(2 * PAGE_BYTES), 1'b0));
      // Address hole between blocks.
      push_header(good_block(0, 3, base, 1'b0));
      push_header(good_block(1, 3, base + 32'(2 * PAGE_BYTES), 1'b0));
      // Complete file ending at the very top of flash.
      push_header(good_block(0, 3, top - 32'(3 * PAGE_BYTES), 1'b0));
      push_header(good_block(1, 3, top - 32'(2 * PAGE_BYTES), 1'b0));
      push_header(good_block(2, 3, top - 32'(PAGE_BYTES), 1'b1));
      // File marked last before all blocks were seen.
      push_header(good_block(0, 4, base, 1'b0));
      push_header(good_block(1, 4, base + 32'(PAGE_BYTES), 1'b1));
      // Single-block files: one complete, one declaring the largest count.
      push_header(good_block(0, 1, top - 32'(PAGE_BYTES), 1'b1));
      push_header(good_block(0, 32'hFFFF_FFFF, base, 1'b1));
   endtask

   // Request driver: presents queued headers with random gaps between them.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            pending_verdicts.insert(pending_verdicts.size(), judge_header(driven));
            headers_sent++;
         end
         if (req_valid && req_stall) begin
            // Stalled: hold the request as it is.
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (header_backlog.size() != 0) begin
            driven = header_backlog.pop_front();
            req_magic_first <= driven.magic_first;
            req_magic_second <= driven.magic_second;
            req_magic_final <= driven.magic_final;
            req_flags_word <= driven.flags_word;
            req_family_word <= driven.family_word;
            req_payload_bytes <= driven.payload_bytes;
            req_target_address <= driven.target_address;
            req_block_number <= driven.block_number;
            req_block_count <= driven.block_count;
            req_last_in_file <= driven.last_in_file;
            req_valid <= 1'b1;
            if ($urandom_range(0, 99) < sender_idle_pct) send_gap = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result monitor: checks each accepted result against the oldest verdict.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_verdicts.size() == 0) begin
               report_mismatch($sformatf("result with status %0d and no request outstanding",
                                         rsp_status));
            end else begin
               result_type want;
               want = pending_verdicts.pop_front();
               verdicts_checked++;
               status_seen[want.status] = 1'b1;
               if (want.file_complete) files_closed++;
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("result %0d: status %0d, expected %0d",
                                            verdicts_checked, rsp_status, want.status));
               if (rsp_base_address !== want.base_address)
                  report_mismatch($sformatf("result %0d: base_address %h, expected %h",
                                            verdicts_checked, rsp_base_address,
                                            want.base_address));
               if (rsp_page_index !== want.page_index)
                  report_mismatch($sformatf("result %0d: page_index %0d, expected %0d",
                                            verdicts_checked, rsp_page_index,
                                            want.page_index));
               if (rsp_file_complete !== want.file_complete)
                  report_mismatch($sformatf("result %0d: file_complete %b, expected %b",
                                            verdicts_checked, rsp_file_complete,
                                            want.file_complete));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if ($urandom_range(0, 99) < receiver_idle_pct) begin
            stall_left = pick_gap() - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Main sequence: reset, directed headers, then random files under several settings.
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      sender_idle_pct = 25;
      receiver_idle_pct = 25;
      queue_directed();
      wait_drained();

      set_config(1'b1, $urandom, 32'h2000_0000, 25'h000_4000, 25'h010_0000);
      run_random_phase(90, 30, 30);

      // Smallest window: one page of flash at address zero.
      set_config(1'b0, 32'h0000_0000, 32'h0000_0000, 25'h000_0000, 25'h000_0100);
      run_random_phase(50, 20, 20);

      // Window reaching past the top of the address space, no idling.
      set_config(1'b1, 32'hFFFF_FFFF, 32'hFFFF_0000, 25'h000_0100, 25'h100_0000);
      run_random_phase(80, 0, 0);

      // Bootloader area larger than flash leaves an empty window.
      set_config(1'b1, FAMILY_ID_RESET, 32'h0800_0000, 25'h100_0000, 25'h000_8000);
      run_random_phase(25, 40, 10);

      set_config(1'($urandom_range(0, 1)), $urandom, $urandom,
                 25'($urandom_range(0, 32'h1_0000)), 25'($urandom_range(256, 32'h100_0000)));
      run_random_phase(100, 50, 50);

      set_config(1'b0, FAMILY_ID_RESET, FLASH_START_RESET, BOOT_RESERVE_RESET,
                 FLASH_SIZE_RESET);
      write_reg(REG_SPARE, $urandom);
      run_random_phase(100, 25, 40);

      repeat (8) @(posedge clock);
      $display("Checked %0d results for %0d block headers under %0d register settings.",
               verdicts_checked, headers_sent, settings_used);
      $display("Files closed complete: %0d; distinct status codes seen: %0d of 14.",
               files_closed, $countones(status_seen));
      if (mismatch_count == 0) begin
         $display("uf2_block_sequence_checker verification clean");
      end else begin
         $display("uf2_block_sequence_checker verification failed");
      end
      $finish;
   end

   // Hang guard.
   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("Timed out with %0d results still awaited.", pending_verdicts.size());
      $display("uf2_block_sequence_checker verification failed");
      $finish;
   end

endmodule
